/* hdl/bmah_pkg.sv */
// Shared types and constants of the bitmap allocator.
package bmah_pkg;

    localparam int MAP_WORDS = 4096;
    localparam int WORD_BITS = 16;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = ADDR_W + 4;
    localparam int WIDE_W    = (IDX_W + 1 > 17) ? IDX_W + 1 : 17;
    localparam int CAP_BITS  = MAP_WORDS * WORD_BITS;

    localparam int KIND_W    = 2;
    localparam int NUM_W     = 17;
    localparam int LIMIT_W   = 17;
    localparam int OFFSET_W  = 16;
    localparam int CFG_W     = 17;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

    localparam logic CFG_BIT_LIMIT     = 1'b0;
    localparam logic CFG_NUMBER_OFFSET = 1'b1;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 17'd65536;
    localparam logic [WORD_BITS-1:0] FULL_WORD   = {WORD_BITS{1'b1}};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NUM_W-1:0]  block_number;
    } cmd_t;

    typedef struct packed {
        logic             ok;
        logic [NUM_W-1:0] value;
        logic             modified;
    } result_t;

    typedef struct packed {
        logic [WIDE_W-1:0]   lim;
        logic [OFFSET_W-1:0] offset;
    } cfg_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } mem_req_t;

endpackage

/* hdl/bitmap_allocator_with_hint.sv */
// Top level: configuration registers, bitmap RAM, post-reset clearing sweep.
// A rejected or unknown item is answered without a RAM access; free does one read-modify-write;
// allocate scans bitmap words upward from the hint word, one RAM read per cycle;
// count sweeps the words below the bit limit, up to 4096.
// One item at a time; busy stays high until the result strobe, the receiver cannot stall.
// After reset the RAM is swept one word per cycle with busy high.
module bitmap_allocator_with_hint (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  bmah_pkg::cmd_t               cmd,
    output logic                         busy,
    output logic                         done,
    output bmah_pkg::result_t            result,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bmah_pkg::CFG_W-1:0]   cfg_data
);
    import bmah_pkg::*;

    logic [LIMIT_W-1:0]   bit_limit_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic                 clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    cfg_t                 cfg;
    mem_req_t             eng_req;
    logic                 eng_busy;
    logic [WORD_BITS-1:0] rdata;
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic [WIDE_W-1:0]    limit_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_limit_reg <= LIMIT_RESET;
            offset_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_LIMIT:     bit_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_NUMBER_OFFSET: offset_reg    <= cfg_data[OFFSET_W-1:0];
                default:           bit_limit_reg <= bit_limit_reg;
            endcase
        end
    end

    assign limit_w    = WIDE_W'(bit_limit_reg);
    assign cfg.lim    = (limit_w < WIDE_W'(CAP_BITS)) ? limit_w : WIDE_W'(CAP_BITS);
    assign cfg.offset = offset_reg;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == ADDR_W'(MAP_WORDS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // the sweep sets bit 0: index zero marks a failed allocation
    assign ram_wr_en   = clr_active_reg | eng_req.wr_en;
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : eng_req.wr_addr;
    assign ram_wr_data = clr_active_reg ?
                         ((clr_addr_reg == '0) ? WORD_BITS'(1) : '0) : eng_req.wr_data;

    assign busy = clr_active_reg | eng_busy;

    bmah_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (eng_req.rd_en),
        .rd_addr (eng_req.rd_addr),
        .rd_data (rdata),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    bmah_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start & ~busy),
        .cmd     (cmd),
        .cfg     (cfg),
        .busy    (eng_busy),
        .done    (done),
        .result  (result),
        .mem_req (eng_req),
        .rdata   (rdata)
    );

endmodule

/* hdl/bmah_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bmah_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/bmah_engine.sv */
// Command sequencer: word scan for allocate, read-modify-write for free, count sweep.
module bmah_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  bmah_pkg::cmd_t                  cmd,
    input  bmah_pkg::cfg_t                  cfg,
    output logic                            busy,
    output logic                            done,
    output bmah_pkg::result_t               result,
    output bmah_pkg::mem_req_t              mem_req,
    input  logic [bmah_pkg::WORD_BITS-1:0]  rdata
);
    import bmah_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_FREE  = 2'd2;
    localparam logic [1:0] S_COUNT = 2'd3;

    function automatic logic [4:0] ones16(input logic [WORD_BITS-1:0] w);
        logic [4:0] n;
        n = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            n = n + 5'(w[b]);
        end
        return n;
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [ADDR_W:0]     ptr_reg, ptr_next;
    logic                rdv_reg, rdv_next;
    logic [ADDR_W-1:0]   dword_reg, dword_next;
    logic [ADDR_W-1:0]   last_reg, last_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [NUM_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    hint_reg, hint_next;
    logic                mod_reg, mod_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    logic [WIDE_W-1:0]   last_w;
    logic [ADDR_W-1:0]   last_c;
    logic [NUM_W:0]      diff;
    logic [WIDE_W-1:0]   fidx_w;
    logic                free_in_range;
    logic [3:0]          jz;
    logic [IDX_W-1:0]    aidx;
    logic                issue;
    logic [WORD_BITS-1:0] cmask;
    logic [WORD_BITS-1:0] bitsel;
    logic [NUM_W-1:0]    cnt_sum;

    assign last_w        = (cfg.lim - WIDE_W'(1)) >> 4;
    assign last_c        = last_w[ADDR_W-1:0];
    assign diff          = {1'b0, cmd.block_number} - (NUM_W + 1)'(cfg.offset);
    assign fidx_w        = WIDE_W'(diff[NUM_W-1:0]);
    assign free_in_range = !diff[NUM_W] && (fidx_w < cfg.lim);
    assign aidx          = {dword_reg, jz};
    assign issue         = ptr_reg <= {1'b0, last_reg};
    assign bitsel        = WORD_BITS'(1) << idx_reg[3:0];

    always_comb
    begin
        jz = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!rdata[b])
            begin
                jz = 4'(b);
            end
        end
    end

    always_comb
    begin
        if ((dword_reg == last_reg) && (cfg.lim[3:0] != 4'd0))
        begin
            cmask = (WORD_BITS'(1) << cfg.lim[3:0]) - WORD_BITS'(1);
        end
        else
        begin
            cmask = FULL_WORD;
        end
    end

    assign cnt_sum = cnt_reg + NUM_W'(ones16(rdata & cmask));

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        rdv_next   = 1'b0;
        dword_next = dword_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        hint_next  = hint_reg;
        mod_next   = mod_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_req    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next.ok    = 1'b0;
                    res_next.value = '0;
                    case (cmd.kind)
                        KIND_ALLOC:
                        begin
                            if ((cfg.lim == '0) || (hint_reg[IDX_W-1:4] > last_c))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                                ptr_next   = {1'b0, hint_reg[IDX_W-1:4]};
                                last_next  = last_c;
                            end
                        end
                        KIND_FREE:
                        begin
                            if (free_in_range)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = fidx_w[IDX_W-1:4];
                                idx_next        = fidx_w[IDX_W-1:0];
                                state_next      = S_FREE;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        KIND_COUNT:
                        begin
                            if (cfg.lim == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_COUNT;
                                ptr_next   = '0;
                                cnt_next   = '0;
                                last_next  = last_c;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                mem_req.rd_en   = issue;
                mem_req.rd_addr = ptr_reg[ADDR_W-1:0];
                rdv_next        = issue;
                dword_next      = ptr_reg[ADDR_W-1:0];
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    if (rdata != FULL_WORD)
                    begin
                        state_next = S_IDLE;
                        rdv_next   = 1'b0;
                        done_next  = 1'b1;
                        if (WIDE_W'(aidx) < cfg.lim)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = dword_reg;
                            mem_req.wr_data = rdata | (WORD_BITS'(1) << jz);
                            if (aidx != '0)
                            begin
                                mod_next       = 1'b1;
                                res_next.ok    = 1'b1;
                                res_next.value = NUM_W'(aidx) + NUM_W'(cfg.offset);
                                if (aidx > hint_reg)
                                begin
                                    hint_next = aidx;
                                end
                            end
                        end
                    end
                    else if (dword_reg == last_reg)
                    begin
                        state_next = S_IDLE;
                        rdv_next   = 1'b0;
                        done_next  = 1'b1;
                    end
                end
            end
            S_FREE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg[IDX_W-1:4];
                mem_req.wr_data = rdata & ~bitsel;
                mod_next        = 1'b1;
                res_next.ok     = |(rdata & bitsel);
                if (idx_reg < hint_reg)
                begin
                    hint_next = idx_reg;
                end
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_COUNT:
            begin
                mem_req.rd_en   = issue;
                mem_req.rd_addr = ptr_reg[ADDR_W-1:0];
                rdv_next        = issue;
                dword_next      = ptr_reg[ADDR_W-1:0];
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    cnt_next = cnt_sum;
                    if (dword_reg == last_reg)
                    begin
                        state_next     = S_IDLE;
                        rdv_next       = 1'b0;
                        done_next      = 1'b1;
                        res_next.value = cnt_sum;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.modified = mod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rdv_reg   <= 1'b0;
            hint_reg  <= '0;
            mod_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= rdv_next;
            hint_reg  <= hint_next;
            mod_reg   <= mod_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        dword_reg <= dword_next;
        last_reg  <= last_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* hdl/bmah_checker.sv */
// Port-level checks of the allocator, bound to the top level.
module bmah_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               done,
    input  bmah_pkg::result_t  result
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither in progress nor answered");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
        else $error("result without an item");

    a_modified_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.modified) ##1 done |-> result.modified)
        else $error("modified flag dropped");

endmodule

bind bitmap_allocator_with_hint bmah_checker u_bmah_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* tb/tb_top.sv */
// Self-checking testbench for the bitmap allocator: directed and random items.
module tb_top;
    import bmah_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_SETTLE = 3;
    localparam int TAIL_CYCLES  = 50;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 150;

    typedef enum logic [1:0] {P_ITEM, P_WRITE, P_DRAIN} pend_kind_t;

    typedef struct packed {
        pend_kind_t       what;
        cmd_t             item;
        logic             reg_idx;
        logic [CFG_W-1:0] reg_val;
    } pend_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    cmd_t             cmd = '0;
    logic             busy;
    logic             done;
    result_t          result;
    logic             cfg_we = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    pend_t   pending[$];
    result_t outcome_q[$];
    int      errors = 0;

    // shadow copy of the allocator state
    logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
    int                   shadow_hint;
    logic                 shadow_dirty;
    int                   shadow_limit;
    int                   shadow_offset;

    int      gap_left;
    int      settle;
    logic    steady;
    logic    nxt_start;
    logic    nxt_we;
    int      k;
    int      stall_cycles = 0;
    result_t want;

    int plan_limit;
    int plan_offset;
    int phase;
    int n;
    int sel;
    int lim;
    int off;
    int idx;

    bitmap_allocator_with_hint dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t bitmap_outcome(cmd_t c);
        result_t r;
        int      lim_eff;
        int      last;
        int      w;
        int      b;
        int      bit_idx;
        int      num;
        int      cnt;
        r = '0;
        cnt = 0;
        lim_eff = (shadow_limit < CAP_BITS) ? shadow_limit : CAP_BITS;
        case (c.kind)
            KIND_ALLOC:
            begin
                if (lim_eff > 0)
                begin
                    last = (lim_eff - 1) >> 4;
                    w = shadow_hint >> 4;
                    while (w <= last && shadow_map[w] == FULL_WORD)
                        w++;
                    if (w <= last)
                    begin
                        b = 0;
                        while (shadow_map[w][b])
                            b++;
                        bit_idx = w * WORD_BITS + b;
                        if (bit_idx < lim_eff)
                        begin
                            shadow_map[w][b] = 1'b1;
                            if (bit_idx != 0)
                            begin
                                shadow_dirty = 1'b1;
                                if (bit_idx > shadow_hint)
                                    shadow_hint = bit_idx;
                                r.ok = 1'b1;
                                r.value = NUM_W'(bit_idx + shadow_offset);
                            end
                        end
                    end
                end
            end
            KIND_FREE:
            begin
                num = int'(c.block_number);
                if (num >= shadow_offset && num - shadow_offset < lim_eff)
                begin
                    bit_idx = num - shadow_offset;
                    w = bit_idx >> 4;
                    b = bit_idx & 15;
                    r.ok = shadow_map[w][b];
                    shadow_map[w][b] = 1'b0;
                    shadow_dirty = 1'b1;
                    if (bit_idx < shadow_hint)
                        shadow_hint = bit_idx;
                end
            end
            KIND_COUNT:
            begin
                for (w = 0; w < (lim_eff >> 4); w++)
                    cnt += $countones(shadow_map[w]);
                if ((lim_eff & 15) != 0 && (lim_eff >> 4) < MAP_WORDS)
                    cnt += $countones(shadow_map[lim_eff >> 4]
                                      & ((16'd1 << (lim_eff & 15)) - 16'd1));
                r.value = NUM_W'(cnt);
            end
            default:
            begin
            end
        endcase
        r.modified = shadow_dirty;
        return r;
    endfunction

    // driver: issues pending items, register writes and drain pauses
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cmd       <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= 1'b0;
            cfg_data  <= '0;
            gap_left = 0;
            settle = 0;
            steady = 1'b0;
            for (k = 0; k < MAP_WORDS; k++)
                shadow_map[k] = '0;
            shadow_map[0] = 16'd1;
            shadow_hint = 0;
            shadow_dirty = 1'b0;
            shadow_limit = int'(LIMIT_RESET);
            shadow_offset = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BIT_LIMIT)
                    shadow_limit = int'(cfg_data);
                else
                    shadow_offset = int'(cfg_data[OFFSET_W-1:0]);
            end
            if (start && !busy)
            begin
                outcome_q.push_back(bitmap_outcome(cmd));
                if ($urandom_range(0, 31) == 0)
                    steady = !steady;
                gap_left = steady ? 0 : $urandom_range(0, 18);
            end
            nxt_start = start && busy;
            nxt_we = 1'b0;
            if (!nxt_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() > 0)
                begin
                    case (pending[0].what)
                        P_ITEM:
                        begin
                            nxt_start = 1'b1;
                            cmd <= pending[0].item;
                            pending.delete(0);
                        end
                        P_WRITE:
                        begin
                            nxt_we = 1'b1;
                            cfg_index <= pending[0].reg_idx;
                            cfg_data  <= pending[0].reg_val;
                            pending.delete(0);
                        end
                        default:
                        begin
                            if (outcome_q.size() == 0 && !busy && !done)
                            begin
                                if (settle >= DRAIN_SETTLE)
                                begin
                                    settle = 0;
                                    pending.delete(0);
                                end
                                else
                                    settle++;
                            end
                            else
                                settle = 0;
                        end
                    endcase
                end
            end
            start  <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    task automatic compare_field(string name, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // monitor: every strobed result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual ok=%0b value=%0d mod=%0b",
                         $time, result.ok, result.value, result.modified);
                errors++;
            end
            else
            begin
                want = outcome_q[0];
                outcome_q.delete(0);
                compare_field("ok", int'(want.ok), int'(result.ok));
                compare_field("value", int'(want.value), int'(result.value));
                compare_field("modified", int'(want.modified), int'(result.modified));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stall_cycles = 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
            stall_cycles++;
    end

    task automatic add_item(logic [KIND_W-1:0] kind, logic [NUM_W-1:0] number);
        pend_t e;
        e = '0;
        e.what = P_ITEM;
        e.item.kind = kind;
        e.item.block_number = number;
        pending.push_back(e);
    endtask

    task automatic add_drain();
        pend_t e;
        e = '0;
        e.what = P_DRAIN;
        pending.push_back(e);
    endtask

    // register writes always follow a drain so the block is idle
    task automatic add_write(logic reg_idx, int val);
        pend_t e;
        add_drain();
        e = '0;
        e.what = P_WRITE;
        e.reg_idx = reg_idx;
        e.reg_val = CFG_W'(val);
        pending.push_back(e);
        if (reg_idx == CFG_BIT_LIMIT)
            plan_limit = val;
        else
            plan_offset = val;
    endtask

    initial
    begin
        plan_limit = int'(LIMIT_RESET);
        plan_offset = 0;

        // wait out the clearing sweep, then directed items at reset settings
        add_drain();
        add_item(KIND_COUNT, 17'h1FFFF);
        add_item(KIND_ALLOC, 17'd0);
        add_item(KIND_ALLOC, 17'h1FFFF);
        add_item(KIND_FREE, 17'd1);
        add_item(KIND_FREE, 17'd1);
        add_item(KIND_ALLOC, 17'd0);
        add_item(KIND_FREE, 17'd0);
        add_item(KIND_ALLOC, 17'd0);
        add_item(KIND_FREE, 17'h1FFFF);
        add_item(KIND_UNUSED, 17'h1FFFF);
        add_item(KIND_COUNT, 17'd0);

        // limit on a word boundary, largest offset
        add_write(CFG_BIT_LIMIT, 48);
        add_write(CFG_NUMBER_OFFSET, 65535);
        add_item(KIND_ALLOC, 17'd0);
        add_item(KIND_FREE, 17'd65538);
        add_item(KIND_FREE, 17'd100);
        add_item(KIND_FREE, 17'd65583);
        add_item(KIND_FREE, 17'd65582);
        add_item(KIND_COUNT, 17'd0);

        // smallest non-zero limit
        add_write(CFG_BIT_LIMIT, 1);
        add_write(CFG_NUMBER_OFFSET, 0);
        add_item(KIND_ALLOC, 17'd0);
        add_item(KIND_COUNT, 17'd0);
        add_item(KIND_FREE, 17'd0);
        add_item(KIND_ALLOC, 17'd0);

        add_write(CFG_BIT_LIMIT, CAP_BITS);
        add_write(CFG_NUMBER_OFFSET, 65535);
        add_item(KIND_ALLOC, 17'd0);
        add_item(KIND_ALLOC, 17'd0);
        add_item(KIND_COUNT, 17'd0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            sel = $urandom_range(0, 9);
            if (phase == 6)
                lim = CAP_BITS;
            else if (phase == 7)
                lim = 16;
            else if (sel < 6)
                lim = $urandom_range(1, 400);
            else if (sel < 8)
                lim = 16 * $urandom_range(1, 40);
            else
                lim = $urandom_range(401, 4000);
            add_write(CFG_BIT_LIMIT, lim);
            sel = $urandom_range(0, 3);
            off = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 65535);
            add_write(CFG_NUMBER_OFFSET, off);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 50)
                    add_item(KIND_ALLOC, NUM_W'($urandom_range(0, 131071)));
                else if (sel < 80)
                begin
                    idx = $urandom_range(0, ((plan_limit < 512) ? plan_limit : 512) + 1);
                    add_item(KIND_FREE, NUM_W'(plan_offset + idx));
                end
                else if (sel < 90)
                    add_item(KIND_COUNT, NUM_W'($urandom_range(0, 131071)));
                else if (sel < 95)
                    add_item(KIND_UNUSED, NUM_W'($urandom_range(0, 131071)));
                else
                    add_item(KIND_FREE, NUM_W'($urandom_range(0, 131071)));
                if ($urandom_range(0, 49) == 0)
                    add_drain();
            end
            // push the hint past the first word before the small limit phase
            if (phase == 6)
                for (n = 0; n < 20; n++)
                    add_item(KIND_ALLOC, NUM_W'($urandom_range(0, 131071)));
        end
        add_drain();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || outcome_q.size() != 0 || start)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* bitmap_allocator_with_hint.f */
hdl/bmah_pkg.sv
hdl/bmah_ram.sv
hdl/bmah_engine.sv
hdl/bitmap_allocator_with_hint.sv
hdl/bmah_checker.sv
tb/tb_top.sv
